/* src/mlr_pkg.sv */
// Shared types, constants and codes for the MIDI loop recorder.
// No dependencies; imported by every module of the block except the RAM.
package mlr_pkg;

    localparam int STORE_DEPTH   = 1024;
    localparam int MAX_PER_TICK  = 63;

    localparam int TIME_W   = 32;

    // bar length is three times a power of two
    localparam int BAR_SHIFT     = 8;
    localparam int TICKS_PER_BAR = 3 << BAR_SHIFT;
    localparam int BAR_DIGITS    = (TIME_W - BAR_SHIFT) / 2;
    localparam int SUM_W         = $clog2(3 * BAR_DIGITS + 1);

    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int COUNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int REM_W    = BAR_SHIFT + 2;
    localparam int BURST_W  = $clog2(MAX_PER_TICK + 1);

    localparam int BAR_3Q   = TICKS_PER_BAR * 3 / 4;
    localparam int BAR_1Q   = TICKS_PER_BAR / 4;

    localparam logic [15:0] NOTE_MASK = 16'hFF80;

    // input kinds
    localparam logic [1:0] KIND_MIDI   = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // result kinds
    localparam logic [1:0] RK_MIDI    = 2'd0;
    localparam logic [1:0] RK_ALL_OFF = 2'd1;
    localparam logic [1:0] RK_STATUS  = 2'd2;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ARM  = 2'd1,
        MODE_REC  = 2'd2,
        MODE_PLAY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_TK_RD,
        S_TK_CHK,
        S_RESP
    } t_state;

    typedef enum logic {
        OP_ARM,
        OP_PLAY
    } t_rem_op;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [3:0]        chan;
        logic [6:0]        note;
        logic [7:0]        val;
    } t_entry;

endpackage

/* src/midi_loop_recorder.sv */
// MIDI loop recorder top level: mode sequencer, event store and playback walker.
// Depends on mlr_pkg, mlr_event_ram and mlr_bar_rem.
//
// The recorder takes one transaction at a time. A received MIDI event, a button press
// that does not fix a loop bound, or a tick with nothing to play goes to the response
// state, which loads its status result into the output register. A button press or
// armed note that rounds a time to a bar waits on the two-stage remainder unit first. A
// playing tick walks the event store one entry at a time (memory read, then due check
// and emit), at most MAX_PER_TICK entries, then gives its status result; a stalled
// result output holds the walk. The store needs no clearing pass: only entries below the
// fill count are read. The output register lets a new transaction be accepted while the
// last result still waits.
module midi_loop_recorder import mlr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,      // record_channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // event_time, event_channel, event_control, event_value
    input  logic [1:0]  s_axis_tuser,    // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // out_channel, out_note, out_value, current_mode
    output logic [1:0]  m_axis_tuser,    // result_kind
    output logic        m_axis_tlast     // last_of_run
);

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    t_rem_op             r_rem_op, n_rem_op;
    logic [3:0]          r_rec_chan;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0]   r_index, n_index;
    logic [TIME_W-1:0]   r_loop_begin, n_loop_begin;
    logic [TIME_W-1:0]   r_loop_len, n_loop_len;
    logic [TIME_W-1:0]   r_base, n_base;
    logic [BURST_W-1:0]  r_burst, n_burst;
    logic [1:0]          r_rkind, n_rkind;
    t_entry              r_in, n_in;

    logic                r_out_valid;
    logic [1:0]          r_out_kind;
    logic [3:0]          r_out_chan;
    logic [6:0]          r_out_note;
    logic [7:0]          r_out_val;
    logic [1:0]          r_out_mode;
    logic                r_out_last;

    logic                out_free, out_load, out_last;
    logic [1:0]          out_kind;
    logic [3:0]          out_chan;
    logic [6:0]          out_note;
    logic [7:0]          out_val;

    logic                in_fire, rec_ok;
    logic [1:0]          in_kind;
    t_entry              in_entry;
    logic [15:0]         in_ctl;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    t_entry              ram_wdata, rd_entry;
    logic [$bits(t_entry)-1:0] ram_rdata;

    logic                rem_start, rem_done;
    logic [REM_W-1:0]    rem;
    logic [TIME_W-1:0]   bar_floor, due;
    logic [ADDR_W-1:0]   rd_idx;

    assign in_kind         = s_axis_tuser[1:0];
    assign in_entry.tstamp = s_axis_tdata[31:0];
    assign in_entry.chan   = s_axis_tdata[35:32];
    assign in_ctl          = s_axis_tdata[51:36];
    assign in_entry.note   = in_ctl[6:0];
    assign in_entry.val    = s_axis_tdata[59:52];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign rec_ok = (r_count < COUNT_W'(STORE_DEPTH))
                 && (r_mode == MODE_ARM || r_mode == MODE_REC)
                 && ((in_ctl & NOTE_MASK) == 16'd0)
                 && (in_entry.chan == r_rec_chan);

    assign rd_entry  = t_entry'(ram_rdata);
    assign bar_floor = r_in.tstamp - TIME_W'(rem);
    assign due       = rd_entry.tstamp + r_base;

    mlr_event_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH ($bits(t_entry))
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mlr_bar_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (in_entry.tstamp),
        .o_done  (rem_done),
        .o_rem   (rem)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_rem_op     = r_rem_op;
        n_count      = r_count;
        n_index      = r_index;
        n_loop_begin = r_loop_begin;
        n_loop_len   = r_loop_len;
        n_base       = r_base;
        n_burst      = r_burst;
        n_rkind      = r_rkind;
        n_in         = r_in;
        ram_we       = 1'b0;
        ram_waddr    = r_count[ADDR_W-1:0];
        ram_wdata    = r_in;
        ram_re       = 1'b0;
        ram_raddr    = r_index;
        rd_idx       = r_index;
        rem_start    = 1'b0;
        out_load     = 1'b0;
        out_kind     = r_rkind;
        out_chan     = 4'd0;
        out_note     = 7'd0;
        out_val      = 8'd0;
        out_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_in    = in_entry;
                    n_rkind = RK_STATUS;
                    n_state = S_RESP;
                    unique case (in_kind)
                        KIND_MIDI: begin
                            if (rec_ok && r_mode == MODE_ARM) begin
                                rem_start = 1'b1;
                                n_rem_op  = OP_ARM;
                                n_state   = S_REM;
                            end else if (rec_ok) begin
                                ram_we    = 1'b1;
                                ram_wdata = in_entry;
                                n_count   = r_count + COUNT_W'(1);
                            end
                        end
                        KIND_BUTTON: begin
                            unique case (r_mode)
                                MODE_OFF: begin
                                    n_mode = MODE_ARM;
                                end
                                MODE_REC: begin
                                    rem_start = 1'b1;
                                    n_rem_op  = OP_PLAY;
                                    n_state   = S_REM;
                                end
                                default: begin
                                    n_mode  = MODE_OFF;
                                    n_count = '0;
                                    n_index = '0;
                                    n_rkind = RK_ALL_OFF;
                                end
                            endcase
                        end
                        KIND_TICK: begin
                            if (r_mode == MODE_PLAY && r_count != '0) begin
                                n_burst = '0;
                                n_state = S_TK_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REM: begin
                if (rem_done) begin
                    n_index = '0;
                    n_state = S_RESP;
                    if (r_rem_op == OP_ARM) begin
                        n_loop_begin = bar_floor
                            + ((rem > REM_W'(BAR_3Q)) ? TIME_W'(TICKS_PER_BAR) : '0);
                        n_count   = COUNT_W'(1);
                        n_mode    = MODE_REC;
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                    end else begin
                        n_loop_len = bar_floor
                            + ((rem >= REM_W'(BAR_1Q)) ? TIME_W'(TICKS_PER_BAR) : '0)
                            - r_loop_begin;
                        n_base = n_loop_len;
                        n_mode = MODE_PLAY;
                    end
                end
            end
            S_TK_RD: begin
                if (r_burst == BURST_W'(MAX_PER_TICK)) begin
                    n_state = S_RESP;
                end else begin
                    if (COUNT_W'(r_index) >= r_count) begin
                        rd_idx = '0;
                    end
                    n_index   = rd_idx;
                    ram_re    = 1'b1;
                    ram_raddr = rd_idx;
                    n_state   = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (due > r_in.tstamp) begin
                    n_state = S_RESP;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_kind = RK_MIDI;
                    out_chan = rd_entry.chan;
                    out_note = rd_entry.note;
                    out_val  = rd_entry.val;
                    out_last = 1'b0;
                    n_burst  = r_burst + BURST_W'(1);
                    if (COUNT_W'(r_index) + COUNT_W'(1) >= r_count) begin
                        n_index = '0;
                        n_base  = r_base + r_loop_len;
                    end else begin
                        n_index = r_index + ADDR_W'(1);
                    end
                    n_state = S_TK_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_OFF;
            r_rem_op     <= OP_ARM;
            r_rec_chan   <= 4'd0;
            r_count      <= '0;
            r_index      <= '0;
            r_loop_begin <= '0;
            r_loop_len   <= '0;
            r_base       <= '0;
            r_burst      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_rem_op     <= n_rem_op;
            r_count      <= n_count;
            r_index      <= n_index;
            r_loop_begin <= n_loop_begin;
            r_loop_len   <= n_loop_len;
            r_base       <= n_base;
            r_burst      <= n_burst;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rec_chan <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_rkind <= n_rkind;
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_chan <= out_chan;
            r_out_note <= out_note;
            r_out_val  <= out_val;
            r_out_mode <= n_mode;
            r_out_last <= out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_mode, r_out_val, r_out_note, r_out_chan};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_CHK) |-> (COUNT_W'(r_index) < r_count))
        else $error("playback read outside filled entries");

    a_walk_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_CHK) |-> (r_mode == MODE_PLAY && r_burst < BURST_W'(MAX_PER_TICK)))
        else $error("playback walk outside play mode or past burst limit");

    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> (r_state == S_REM))
        else $error("remainder result with no rounding pending");

endmodule

/* src/mlr_event_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Read data register holds while no read is issued. No dependencies.
module mlr_event_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 51,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mlr_bar_rem.sv */
// Remainder of a timestamp modulo the bar length in two pipelined stages.
// Low bits pass through; the high part is reduced mod 3 by base-4 digit sums. Depends on mlr_pkg.
module mlr_bar_rem import mlr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_value,
    output logic              o_done,
    output logic [REM_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [BAR_SHIFT-1:0] r_low;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [3:0]           fold;

    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < BAR_DIGITS; k++) begin
            n_sum = n_sum + SUM_W'(i_value[BAR_SHIFT + 2*k +: 2]);
        end
    end

    always_comb begin
        fold = '0;
        for (int k = 0; k < SUM_W / 2; k++) begin
            fold = fold + 4'(r_sum[2*k +: 2]);
        end
        if (fold >= 4'd6) begin
            fold = fold - 4'd6;
        end
        if (fold >= 4'd3) begin
            fold = fold - 4'd3;
        end
        n_rem = {fold[1:0], r_low};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= n_sum;
            r_low <= i_value[BAR_SHIFT-1:0];
        end
        if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* tb/mlr_checker.sv */
// Checker for the MIDI loop recorder: watches the config, input and result streams,
// predicts every result from its own copy of the recorder state and compares in order.
// Depends on mlr_pkg.
module mlr_checker import mlr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,     // event_time, event_channel, event_control, event_value
    input  logic [1:0]  i_in_user,     // kind
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,    // out_channel, out_note, out_value, current_mode
    input  logic [1:0]  i_out_user,    // result_kind
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam logic [31:0] BAR = 32'(TICKS_PER_BAR);

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] chan;
        logic [6:0] note;
        logic [7:0] val;
        t_mode      mode;
        logic       last;
    } t_playout;

    t_entry      take_mem [STORE_DEPTH];
    int unsigned take_count;
    int unsigned play_pos;
    logic [31:0] loop_pass;
    logic [31:0] loop_start;
    logic [31:0] loop_stop;
    t_mode       rec_mode;
    logic [3:0]  rec_chan;
    t_playout    playout_q [$];
    int          fail_count = 0;
    int          checked = 0;

    task automatic log_playout(logic [1:0] kind, logic [3:0] chan, logic [6:0] note,
                               logic [7:0] val, logic last);
        playout_q.push_back('{kind: kind, chan: chan, note: note, val: val,
                              mode: rec_mode, last: last});
    endtask

    task automatic drop_take();
        take_count = 0;
        play_pos   = 0;
        loop_pass  = '0;
    endtask

    task automatic predict_transaction(logic [1:0] kind, logic [31:0] tm, logic [3:0] ch,
                                       logic [15:0] ctl, logic [7:0] val);
        int          burst;
        logic [31:0] due;
        t_entry      ev;
        logic        all_off;
        burst   = 0;
        all_off = 1'b0;
        case (kind)
            KIND_MIDI: begin
                if (take_count < STORE_DEPTH && (rec_mode == MODE_ARM || rec_mode == MODE_REC)
                    && (ctl & NOTE_MASK) == '0 && ch == rec_chan) begin
                    if (rec_mode == MODE_ARM) begin
                        loop_start = (tm / BAR) * BAR;
                        if (tm % BAR > 32'(BAR_3Q))
                            loop_start = loop_start + BAR;
                        drop_take();
                        rec_mode = MODE_REC;
                    end
                    take_mem[take_count] = '{tstamp: tm, chan: ch, note: ctl[6:0], val: val};
                    take_count++;
                end
                log_playout(RK_STATUS, '0, '0, '0, 1'b1);
            end
            KIND_BUTTON: begin
                if (rec_mode == MODE_OFF) begin
                    rec_mode = MODE_ARM;
                end else if (rec_mode == MODE_REC) begin
                    rec_mode  = MODE_PLAY;
                    loop_stop = (tm / BAR) * BAR;
                    if (tm % BAR >= 32'(BAR_1Q))
                        loop_stop = loop_stop + BAR;
                    play_pos  = 0;
                    loop_pass = '0;
                end else begin
                    rec_mode = MODE_OFF;
                    drop_take();
                    all_off  = 1'b1;
                end
                log_playout(all_off ? RK_ALL_OFF : RK_STATUS, '0, '0, '0, 1'b1);
            end
            default: begin
                if (kind == KIND_TICK && rec_mode == MODE_PLAY && take_count > 0) begin
                    while (burst < MAX_PER_TICK) begin
                        if (play_pos >= take_count)
                            play_pos = 0;
                        ev  = take_mem[play_pos];
                        due = ev.tstamp + loop_stop + loop_pass * (loop_stop - loop_start)
                              - loop_start;
                        if (due > tm)
                            break;
                        log_playout(RK_MIDI, ev.chan, ev.note, ev.val, 1'b0);
                        burst++;
                        play_pos++;
                        if (play_pos >= take_count) begin
                            play_pos  = 0;
                            loop_pass = loop_pass + 1;
                        end
                    end
                end
                log_playout(RK_STATUS, '0, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_playout exp_out;
        if (playout_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual kind %0d data %h last %b",
                     $time, i_out_user, i_out_data, i_out_last);
            fail_count++;
        end else begin
            exp_out = playout_q.pop_front();
            check_field("result_kind", exp_out.kind, i_out_user);
            check_field("out_channel", exp_out.chan, i_out_data[3:0]);
            check_field("out_note", exp_out.note, i_out_data[10:4]);
            check_field("out_value", exp_out.val, i_out_data[18:11]);
            check_field("current_mode", exp_out.mode, i_out_data[20:19]);
            check_field("last_of_run", exp_out.last, i_out_last);
            checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drop_take();
            loop_start = '0;
            loop_stop  = '0;
            rec_mode   = MODE_OFF;
            rec_chan   = '0;
            playout_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                rec_chan = i_cfg_data;
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                predict_transaction(i_in_user, i_in_data[31:0], i_in_data[35:32],
                                    i_in_data[51:36], i_in_data[59:52]);
        end
        o_fail_count <= fail_count;
        o_pending    <= playout_q.size();
        o_checked    <= checked;
    end

endmodule

/* tb/testbench.sv */
// Top of the MIDI loop recorder testbench: clock, reset, stimulus, receiver and verdict.
// Depends on mlr_pkg, midi_loop_recorder and mlr_checker.
module testbench;
    import mlr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 180;
    localparam int SHORT_TAKE   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count = 0;
    int   sent = 0;
    int   cfg_writes = 0;
    int   hold_asks = 0;
    logic gapless = 1'b0;
    logic [3:0] cur_chan = '0;

    midi_loop_recorder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mlr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap();
        return gapless ? 0 : $urandom_range(0, 11);
    endfunction

    // result side: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int gap;
        int hold_done;
        hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic push_item(logic [1:0] kind, logic [31:0] tm, logic [3:0] ch,
                             logic [15:0] ctl, logic [7:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, val, ctl, ch, tm};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_channel(logic [3:0] ch);
        drain();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ch;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_chan = ch;
        cfg_writes++;
    endtask

    function automatic logic [15:0] rand_note();
        return 16'($urandom_range(0, 127));
    endfunction

    initial begin
        int          i;
        int          n;
        int          sessions;
        int          start_sent;
        logic [31:0] base;
        logic [31:0] tm;
        logic [3:0]  ch;

        @(posedge i_rst_n);
        @(posedge i_clk);

        // directed part, record channel at its reset value
        push_item(KIND_UNUSED, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 8'hFF);
        push_item(KIND_TICK, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_MIDI, 32'd100, 4'd0, 16'd60, 8'h90);
        push_item(KIND_BUTTON, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_BUTTON, 32'd10, 4'd0, 16'd0, 8'd0);         // arm aborted
        push_item(KIND_BUTTON, 32'd20, 4'd0, 16'd0, 8'd0);
        push_item(KIND_MIDI, 32'd4000, 4'd1, 16'd60, 8'h90);       // other channel
        push_item(KIND_MIDI, 32'd4000, 4'd0, 16'd128, 8'h90);      // not a note
        push_item(KIND_MIDI, 32'd4000, 4'd0, 16'hFFFF, 8'h90);
        push_item(KIND_MIDI, 32'd4440, 4'd0, 16'd0, 8'd0);         // rounds up to next bar
        push_item(KIND_MIDI, 32'd4500, 4'd0, 16'd127, 8'hFF);
        push_item(KIND_MIDI, 32'd4908, 4'd0, 16'd64, 8'h80);
        push_item(KIND_MIDI, 32'd5000, 4'd0, 16'hFF80, 8'h7F);
        push_item(KIND_MIDI, 32'd5000, 4'd15, 16'd1, 8'h7F);
        push_item(KIND_BUTTON, 32'd6344, 4'd0, 16'd0, 8'd0);       // loop end rounds up
        push_item(KIND_TICK, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_TICK, 32'd6800, 4'd0, 16'd0, 8'd0);
        push_item(KIND_TICK, 32'h7FFF_FFFF, 4'd0, 16'd0, 8'd0);    // burst limit
        push_item(KIND_TICK, 32'hFFFF_FFFF, 4'd0, 16'd0, 8'd0);
        push_item(KIND_UNUSED, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_BUTTON, 32'd0, 4'd0, 16'd0, 8'd0);          // play to off
        push_item(KIND_BUTTON, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_MIDI, 32'd2112, 4'd0, 16'd5, 8'h91);        // exactly 3/4: rounds down
        push_item(KIND_BUTTON, 32'd2495, 4'd0, 16'd0, 8'd0);       // just under 1/4: down
        push_item(KIND_TICK, 32'd2879, 4'd0, 16'd0, 8'd0);
        push_item(KIND_TICK, 32'd2880, 4'd0, 16'd0, 8'd0);
        push_item(KIND_BUTTON, 32'd3000, 4'd0, 16'd0, 8'd0);

        // take near the top of the time range, loop end wraps past zero
        write_channel(4'd15);
        push_item(KIND_BUTTON, 32'hFFFF_F000, 4'd0, 16'd0, 8'd0);
        push_item(KIND_MIDI, 32'hFFFF_FC00, 4'd15, rand_note(), 8'($urandom_range(0, 255)));
        for (i = 0; i < 6; i++)
            push_item(KIND_MIDI, 32'hFFFF_FC00 + $urandom_range(0, 1000), 4'd15, rand_note(),
                      8'($urandom_range(0, 255)));
        push_item(KIND_BUTTON, 32'hFFFF_FFFF, 4'd0, 16'd0, 8'd0);
        tm = '0;
        for (i = 0; i < 6; i++) begin
            push_item(KIND_TICK, tm, 4'd0, 16'd0, 8'd0);
            tm = tm + $urandom_range(0, 1200);
        end
        push_item(KIND_BUTTON, 32'd0, 4'd0, 16'd0, 8'd0);

        // short take played as a zero-length loop, every tick hits the burst limit
        gapless <= 1'b1;
        push_item(KIND_BUTTON, 32'd0, 4'd0, 16'd0, 8'd0);
        push_item(KIND_MIDI, 32'd0, 4'd15, rand_note(), 8'h90);
        for (i = 0; i < SHORT_TAKE; i++)
            push_item(KIND_MIDI, $urandom_range(0, 3071), 4'd15, rand_note(),
                      8'($urandom_range(0, 255)));
        gapless <= 1'b0;
        push_item(KIND_BUTTON, 32'd100, 4'd0, 16'd0, 8'd0);
        for (i = 0; i < 6; i++)
            push_item(KIND_TICK, 32'd4000, 4'd0, 16'd0, 8'd0);
        push_item(KIND_BUTTON, 32'd4000, 4'd0, 16'd0, 8'd0);

        // random sessions: mostly well-formed takes with random content, some noise
        write_channel(4'($urandom_range(1, 14)));
        start_sent = sent;
        sessions = 0;
        while (sent - start_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_channel(4'($urandom_range(0, 15)));
            gapless <= ($urandom_range(0, 4) == 0);
            if (sessions == 3)
                hold_asks <= hold_asks + 1;
            base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            push_item(KIND_BUTTON, base, 4'($urandom_range(0, 15)), 16'd0, 8'd0);
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 5) == 0)
                    push_item(2'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)),
                              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                ch = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : cur_chan;
                push_item(KIND_MIDI, base + $urandom_range(0, 4 * TICKS_PER_BAR), ch,
                          rand_note(), 8'($urandom_range(0, 255)));
            end
            tm = base + $urandom_range(3 * TICKS_PER_BAR, 6 * TICKS_PER_BAR);
            if ($urandom_range(0, 7) != 0)
                push_item(KIND_BUTTON, tm, 4'd0, 16'd0, 8'd0);
            n = $urandom_range(2, 8);
            for (i = 0; i < n; i++) begin
                tm = tm + $urandom_range(0, 2 * TICKS_PER_BAR);
                push_item(KIND_TICK, tm, 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            push_item(KIND_BUTTON, tm, 4'd0, 16'd0, 8'd0);
            sessions++;
        end
        gapless <= 1'b0;

        drain();
        repeat (300) @(posedge i_clk);
        $display("Run: %0d input transactions, %0d results checked, %0d channel writes.",
                 sent, checked, cfg_writes);
        $display("Took in arm abort, bar rounding both ways, time wrap, zero-length loop %s",
                 "with burst limit and long result stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* midi_loop_recorder.f */
src/mlr_pkg.sv
src/mlr_event_ram.sv
src/mlr_bar_rem.sv
src/midi_loop_recorder.sv
tb/mlr_checker.sv
tb/testbench.sv
